@@ rtl/core/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and default sizes of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   // Fixed field widths
   localparam int MODE_W      = 2;
   localparam int BLOCK_IDX_W = 12;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 13;

   // Default sizes of the map
   localparam int MAX_BLOCKS_DEFAULT = 4096;
   localparam int WORD_BITS_DEFAULT  = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

   typedef logic [MODE_W-1:0]      mode_type;
   typedef logic [BLOCK_IDX_W-1:0] block_idx_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [COUNT_W-1:0]     count_type;

   // Request modes
   localparam mode_type MODE_ALLOC  = 2'd0;
   localparam mode_type MODE_FREE   = 2'd1;
   localparam mode_type MODE_QUERY  = 2'd2;
   localparam mode_type MODE_UNUSED = 2'd3;

   // Response status codes
   localparam status_type ST_OK           = 2'd0;
   localparam status_type ST_NO_FREE      = 2'd1;
   localparam status_type ST_ALREADY_FREE = 2'd2;
   localparam status_type ST_RANGE        = 2'd3;

endpackage : bba_pkg

`default_nettype wire

@@ rtl/core/bba_if.sv @@
// ----------------------------------------------------------------------------
// bba_if
// Valid/ready channels of the allocator: request, response and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
   logic          valid;
   logic          ready;
   mode_type      mode;
   block_idx_type block_index;

   modport source (output valid, output mode, output block_index, input ready);
   modport sink   (input valid, input mode, input block_index, output ready);
endinterface : bba_req_if

interface bba_rsp_if import bba_pkg::*; ();
   logic          valid;
   logic          ready;
   status_type    status;
   block_idx_type result_index;
   logic          bit_value;

   modport source (output valid, output status, output result_index, output bit_value,
                   input ready);
   modport sink   (input valid, input status, input result_index, input bit_value,
                   output ready);
endinterface : bba_rsp_if

interface bba_csr_if import bba_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type block_count;

   modport source (output valid, output block_count, input ready);
   modport sink   (input valid, input block_count, output ready);
endinterface : bba_csr_if

`default_nettype wire

@@ rtl/core/bba_map_ram.sv @@
// ----------------------------------------------------------------------------
// bba_map_ram
// Usage bitmap store: one write and one registered read port. A word never
// written since reset reads as zero (all blocks free).
// ----------------------------------------------------------------------------
`default_nettype none

module bba_map_ram import bba_pkg::*; #(
   parameter int NUM_WORDS = 128,
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   parameter int ADDR_W    = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output      logic [WORD_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] written_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // per-word written flags stand in for clearing the array
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule : bba_map_ram

`default_nettype wire

@@ rtl/core/bba_word_unit.sv @@
// ----------------------------------------------------------------------------
// bba_word_unit
// Shared word unit: lowest free bit below the count limit, single-bit pick
// and single-bit update of one bitmap word.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_word_unit import bba_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   parameter int CNT_W     = 13,
   parameter int BIT_W     = 5
) (
   input  wire logic [WORD_BITS-1:0] word,
   input  wire logic [CNT_W-1:0]     remain,   // blocks left from this word's base
   input  wire logic [BIT_W-1:0]     upd_pos,
   input  wire logic                 upd_val,
   output      logic                 found,
   output      logic [BIT_W-1:0]     first_pos,
   output      logic                 pick_bit,
   output      logic [WORD_BITS-1:0] new_word
);

   logic [WORD_BITS-1:0] free_mask;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         free_mask[b] = ~word[b] && (32'(remain) > b);
      end
   end

   // priority encode, lowest index wins
   always_comb begin
      found     = 1'b0;
      first_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_mask[b]) begin
            found     = 1'b1;
            first_pos = BIT_W'(b);
         end
      end
   end

   assign pick_bit = word[upd_pos];

   always_comb begin
      new_word          = word;
      new_word[upd_pos] = upd_val;
   end

endmodule : bba_word_unit

`default_nettype wire

@@ rtl/core/bitmap_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a used/free bitmap held in one word memory.
// ----------------------------------------------------------------------------
// Usage:
//  req : mode (allocate / free / query) and block_index; one transfer per item.
//  rsp : status, result_index, bit_value; exactly one transfer per request.
//  csr : writes block_count (number of managed blocks, capped at MAX_BLOCKS);
//        always ready, write only while the allocator is idle.
// Path from request transfer to response valid, ending in ST_RESP:
//  - out-of-range, unused mode, zero count: straight to ST_RESP
//  - allocate: ST_SCAN reads words in order until a free bit is found
//    (at most ceil(count / WORD_BITS) words read), then ST_RESP
//  - free / query: ST_LOCATE walks to the indexed word, then ST_BIT, ST_RESP
// One item at a time: req.ready is high only while the sequencer is idle.
// The single bitmap memory and the shared word unit step one word per cycle.
// Reset: every block free at once (per-word written flags, no clearing pass),
// block_count back to 4096.
// Stall: a finished response sits in the output register; the next request is
// still taken. A second result waits in the sequencer until rsp frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_core import bba_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT,
   parameter int WORD_BITS  = WORD_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   bba_req_if.sink   req,
   bba_rsp_if.source rsp,
   bba_csr_if.sink   csr
);

   localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   // holds the effective count and any word base up to count + WORD_BITS
   localparam int CNT_W     = $clog2(MAX_BLOCKS + WORD_BITS + 1);
   localparam int SUM_W     = (CNT_W > BLOCK_IDX_W) ? CNT_W : BLOCK_IDX_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOCATE = 3'd1;   // walk words up to the indexed one
   localparam logic [2:0] ST_SCAN   = 3'd2;   // first-fit search, one word a cycle
   localparam logic [2:0] ST_BIT    = 3'd3;   // free / query on the fetched word
   localparam logic [2:0] ST_RESP   = 3'd4;   // hand result to the output register

   logic [2:0]          state_ff, state_in;
   count_type           count_ff;
   mode_type            mode_ff, mode_in;
   block_idx_type       idx_ff, idx_in;
   logic [ADDR_W-1:0]   word_ff, word_in;
   logic [CNT_W-1:0]    base_ff, base_in;
   logic [BIT_W-1:0]    bitpos_ff, bitpos_in;
   status_type          res_status_ff, res_status_in;
   block_idx_type       res_index_ff, res_index_in;
   logic                res_bit_ff, res_bit_in;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   block_idx_type       rsp_index_ff;
   logic                rsp_bit_ff;

   logic [CNT_W-1:0]    eff_count;
   logic [CNT_W-1:0]    base_next;
   logic [CNT_W-1:0]    remain;
   logic [SUM_W-1:0]    offset;
   logic [SUM_W-1:0]    alloc_sum;
   logic                req_xfer;
   logic                rsp_free;
   logic                load_rsp;

   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                wr_en;
   logic [WORD_BITS-1:0] new_word;

   logic                found;
   logic [BIT_W-1:0]    first_pos;
   logic [BIT_W-1:0]    upd_pos;
   logic                upd_val;
   logic                pick_bit;

   // ---------------------------------------------------------------- config
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr.valid) begin
         count_ff <= csr.block_count;
      end
   end

   // count above capacity behaves as capacity
   assign eff_count = (32'(count_ff) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(count_ff);

   // ---------------------------------------------------------------- datapath
   assign base_next = base_ff + CNT_W'(WORD_BITS);
   assign remain    = eff_count - base_ff;
   assign offset    = SUM_W'(idx_ff) - SUM_W'(base_ff);
   assign alloc_sum = SUM_W'(base_ff) + SUM_W'(first_pos);

   assign upd_pos = (state_ff == ST_SCAN) ? first_pos : bitpos_ff;
   assign upd_val = (state_ff == ST_SCAN);      // allocate sets, free clears

   bba_word_unit #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W),
      .BIT_W     (BIT_W)
   ) u_word_unit (
      .word      (rd_data),
      .remain    (remain),
      .upd_pos   (upd_pos),
      .upd_val   (upd_val),
      .found     (found),
      .first_pos (first_pos),
      .pick_bit  (pick_bit),
      .new_word  (new_word)
   );

   bba_map_ram #(
      .NUM_WORDS (NUM_WORDS),
      .WORD_BITS (WORD_BITS),
      .ADDR_W    (ADDR_W)
   ) u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (new_word)
   );

   // ---------------------------------------------------------------- sequencer
   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign load_rsp  = (state_ff == ST_RESP) && rsp_free;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      bitpos_in     = bitpos_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_bit_in    = res_bit_ff;
      rd_en         = 1'b0;
      rd_addr       = word_ff;
      wr_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in       = req.mode;
               idx_in        = req.block_index;
               word_in       = '0;
               base_in       = '0;
               res_status_in = ST_OK;
               res_index_in  = '0;
               res_bit_in    = 1'b0;
               case (req.mode)
                  MODE_ALLOC: begin
                     if (eff_count == '0) begin
                        res_status_in = ST_NO_FREE;
                        state_in      = ST_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_FREE, MODE_QUERY: begin
                     if (SUM_W'(req.block_index) >= SUM_W'(eff_count)) begin
                        res_status_in = ST_RANGE;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_LOCATE;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;   // unused mode: plain OK, no change
                  end
               endcase
            end
         end

         ST_LOCATE: begin
            if (offset < SUM_W'(WORD_BITS)) begin
               rd_en     = 1'b1;
               bitpos_in = offset[BIT_W-1:0];
               state_in  = ST_BIT;
            end else begin
               word_in = word_ff + 1'b1;
               base_in = base_next;
            end
         end

         ST_SCAN: begin
            if (found) begin
               wr_en        = 1'b1;
               res_index_in = alloc_sum[BLOCK_IDX_W-1:0];
               state_in     = ST_RESP;
            end else if (base_next >= eff_count) begin
               res_status_in = ST_NO_FREE;
               state_in      = ST_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = word_ff + 1'b1;
               word_in = word_ff + 1'b1;
               base_in = base_next;
            end
         end

         ST_BIT: begin
            if (mode_ff == MODE_QUERY) begin
               res_bit_in = pick_bit;
            end else if (pick_bit) begin
               wr_en = 1'b1;
            end else begin
               res_status_in = ST_ALREADY_FREE;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      word_ff       <= word_in;
      base_ff       <= base_in;
      bitpos_ff     <= bitpos_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_bit_ff    <= res_bit_in;
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_bit_ff    <= res_bit_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.result_index = rsp_index_ff;
   assign rsp.bit_value    = rsp_bit_ff;

endmodule : bitmap_block_allocator_core

`default_nettype wire
